// ===== hw/rtl/aes_pkg.sv =====
// Package: shared types, constants and GF/S-box functions for the AES core.
`timescale 1ns / 1ps
package aes_pkg;

    localparam int RkWords = 60;
    localparam int RkAw    = 6;

    localparam logic [2:0] CfgKey0  = 3'd0;
    localparam logic [2:0] CfgKey1  = 3'd1;
    localparam logic [2:0] CfgKey2  = 3'd2;
    localparam logic [2:0] CfgKey3  = 3'd3;
    localparam logic [2:0] CfgIvHi  = 3'd4;
    localparam logic [2:0] CfgIvLo  = 3'd5;
    localparam logic [2:0] CfgKeyLn = 3'd6;
    localparam logic [2:0] CfgMode  = 3'd7;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXPAND,
        ST_PREP,
        ST_ROUND,
        ST_DONE
    } t_state;

    // key store access from the sequencer
    typedef struct packed {
        logic              we;
        logic [RkAw-1:0]   waddr;
        logic [31:0]       wdata;
        logic [RkAw-1:0]   raddr;
    } t_rk_req;

    function automatic logic [7:0] sbox(input logic [7:0] x);
        logic [7:0] t [256];
        t = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        return t[x];
    endfunction

    function automatic logic [7:0] sbox_rev(input logic [7:0] x);
        logic [7:0] t [256];
        t = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
        return t[x];
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
    endfunction

    function automatic logic [7:0] xt(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] mix_col(input logic [31:0] c);
        logic [7:0] a0, a1, a2, a3;
        a0 = c[31:24]; a1 = c[23:16]; a2 = c[15:8]; a3 = c[7:0];
        return {xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3,
                a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3,
                a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3,
                xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3)};
    endfunction

    // inverse mix as a pre-multiply by (4x^2+5) folded before the forward mix
    function automatic logic [31:0] inv_mix_col(input logic [31:0] c);
        logic [7:0] a0, a1, a2, a3, u, v;
        a0 = c[31:24]; a1 = c[23:16]; a2 = c[15:8]; a3 = c[7:0];
        u = xt(xt(a0 ^ a2));
        v = xt(xt(a1 ^ a3));
        return mix_col({a0 ^ u, a1 ^ v, a2 ^ u, a3 ^ v});
    endfunction

    function automatic logic [7:0] rcon(input logic [3:0] i);
        logic [7:0] r;
        case (i)
            4'd1:    r = 8'h01;
            4'd2:    r = 8'h02;
            4'd3:    r = 8'h04;
            4'd4:    r = 8'h08;
            4'd5:    r = 8'h10;
            4'd6:    r = 8'h20;
            4'd7:    r = 8'h40;
            4'd8:    r = 8'h80;
            4'd9:    r = 8'h1b;
            4'd10:   r = 8'h36;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

endpackage

// ===== hw/rtl/aes_block_cipher_ecb_cbc_core.sv =====
// Top level: AES-128/192/256 ECB/CBC block cipher with round-key store.
//  channel | dir | handshake            | payload
//  in      | in  | i_valid / o_ready    | i_block_high, i_block_low, i_first_of_message
//  out     | out | o_valid / i_ready    | o_result_high, o_result_low
//  cfg     | in  | i_cfg_we             | i_cfg_index, i_cfg_wdata
// From acceptance to result, a block passes a prepare state, the rounds and a finish
// state. Each round key word is read from the key store as an address, then registered
// data, four words per round, for each of the Nr+1 key additions (Nr = 10, 12 or 14).
// After a key change the first block first expands 4*(Nr+1) words: words taken from
// the key at one word per cycle, later ones each after a read of a stored word. Reset
// is synchronous, active low, and clears control, chain, key-valid and configuration
// state. A result holds in the output register until taken; the next word may be
// accepted meanwhile and its result waits until the register frees.
`timescale 1ns / 1ps
module aes_block_cipher_ecb_cbc_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [63:0] i_block_high,
    input  logic [63:0] i_block_low,
    input  logic        i_first_of_message,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [63:0] o_result_high,
    output logic [63:0] o_result_low,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_wdata
);
    logic [63:0] r_key [4];
    logic [127:0] r_iv;
    logic [1:0]  r_klen;
    logic [1:0]  r_mode;
    logic        r_keys_ready, n_keys_ready;
    logic [127:0] r_chain, n_chain;
    logic [127:0] r_st, n_st;
    logic [127:0] r_saved, n_saved;
    logic [127:0] r_kbuf, n_kbuf;
    logic [31:0]  r_prev, n_prev;
    aes_pkg::t_state r_state, n_state;
    logic [5:0]  r_idx, n_idx;
    logic [1:0]  r_sub, n_sub;
    logic [3:0]  r_rnd, n_rnd;
    logic        r_rdpend, n_rdpend;
    logic        r_ovalid, n_ovalid;
    logic [127:0] r_res, n_res;
    logic [2:0]  r_kcnt, n_kcnt;
    logic [3:0]  r_kround, n_kround;
    logic [31:0] rdata;
    aes_pkg::t_rk_req rk;
    logic [127:0] rnd_out;
    logic        dec, cbc, rlast;
    logic [3:0]  nr;
    logic [3:0]  nk;
    logic [5:0]  total;
    logic [127:0] kfull;
    logic [31:0] t, kw;

    aes_rk_ram u_ram (.i_clk(i_clk), .i_req(rk), .o_rdata(rdata));

    assign dec   = r_mode[0];
    assign cbc   = r_mode[1];
    assign nr    = (r_klen == 2'd0) ? 4'd10 : (r_klen == 2'd1) ? 4'd12 : 4'd14;
    assign nk    = nr - 4'd6;
    assign total = {nr, 2'b00} + 6'd4;
    assign kfull = {r_kbuf[95:0], rdata};
    // last round: final round number in either direction
    assign rlast = dec ? (r_rnd == 4'd0) : (r_rnd == nr);

    aes_round u_round (.i_state(r_st), .i_key(kfull), .i_dec(dec),
                       .i_last(rlast), .o_state(rnd_out));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key[0] <= '0; r_key[1] <= '0; r_key[2] <= '0; r_key[3] <= '0;
            r_iv <= '0; r_klen <= '0; r_mode <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                aes_pkg::CfgKey0:  r_key[0] <= i_cfg_wdata;
                aes_pkg::CfgKey1:  r_key[1] <= i_cfg_wdata;
                aes_pkg::CfgKey2:  r_key[2] <= i_cfg_wdata;
                aes_pkg::CfgKey3:  r_key[3] <= i_cfg_wdata;
                aes_pkg::CfgIvHi:  r_iv[127:64] <= i_cfg_wdata;
                aes_pkg::CfgIvLo:  r_iv[63:0] <= i_cfg_wdata;
                aes_pkg::CfgKeyLn: r_klen <= (i_cfg_wdata[1:0] == 2'd3) ? 2'd2 : i_cfg_wdata[1:0];
                aes_pkg::CfgMode:  r_mode <= i_cfg_wdata[1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= aes_pkg::ST_IDLE;
            r_keys_ready <= 1'b0;
            r_chain <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_keys_ready <= n_keys_ready;
            r_chain <= n_chain;
            r_ovalid <= n_ovalid;
        end
        r_st <= n_st; r_saved <= n_saved; r_kbuf <= n_kbuf; r_prev <= n_prev;
        r_idx <= n_idx; r_sub <= n_sub; r_rnd <= n_rnd; r_rdpend <= n_rdpend;
        r_res <= n_res; r_kcnt <= n_kcnt; r_kround <= n_kround;
    end

    always_comb begin
        n_state = r_state; n_keys_ready = r_keys_ready; n_chain = r_chain;
        n_st = r_st; n_saved = r_saved; n_kbuf = r_kbuf; n_prev = r_prev;
        n_idx = r_idx; n_sub = r_sub; n_rnd = r_rnd; n_rdpend = r_rdpend;
        n_ovalid = r_ovalid; n_res = r_res; n_kcnt = r_kcnt; n_kround = r_kround;
        rk = '{we: 1'b0, waddr: '0, wdata: '0, raddr: '0};
        o_ready = 1'b0;
        t = r_prev; kw = '0;
        if (i_cfg_we && (i_cfg_index == aes_pkg::CfgKey0 || i_cfg_index == aes_pkg::CfgKey1
            || i_cfg_index == aes_pkg::CfgKey2 || i_cfg_index == aes_pkg::CfgKey3
            || i_cfg_index == aes_pkg::CfgKeyLn)) begin
            n_keys_ready = 1'b0;
        end
        if (r_ovalid && i_ready) begin
            n_ovalid = 1'b0;
        end
        case (r_state)
            aes_pkg::ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_saved = {i_block_high, i_block_low};
                    n_st = {i_block_high, i_block_low};
                    if (cbc && i_first_of_message) begin
                        n_chain = r_iv;
                    end
                    n_idx = '0; n_kcnt = '0; n_kround = 4'd1; n_rdpend = 1'b0;
                    n_state = r_keys_ready ? aes_pkg::ST_PREP : aes_pkg::ST_EXPAND;
                end
            end
            aes_pkg::ST_EXPAND: begin
                // words below nk come from the key; later ones need w[i-nk] from the store
                if (r_idx < 6'(nk)) begin
                    case (r_idx[2:1])
                        2'd0: kw = r_idx[0] ? r_key[0][31:0] : r_key[0][63:32];
                        2'd1: kw = r_idx[0] ? r_key[1][31:0] : r_key[1][63:32];
                        2'd2: kw = r_idx[0] ? r_key[2][31:0] : r_key[2][63:32];
                        default: kw = r_idx[0] ? r_key[3][31:0] : r_key[3][63:32];
                    endcase
                    rk.we = 1'b1; rk.waddr = r_idx; rk.wdata = kw;
                    n_prev = kw; n_idx = r_idx + 6'd1;
                end else if (!r_rdpend) begin
                    rk.raddr = r_idx - 6'(nk);
                    n_rdpend = 1'b1;
                end else begin
                    if (r_kcnt == 3'd0) begin
                        t = aes_pkg::sub_word({r_prev[23:0], r_prev[31:24]})
                            ^ {aes_pkg::rcon(r_kround), 24'h0};
                    end else if (nk == 4'd8 && r_kcnt == 3'd4) begin
                        t = aes_pkg::sub_word(r_prev);
                    end
                    kw = rdata ^ t;
                    rk.we = 1'b1; rk.waddr = r_idx; rk.wdata = kw;
                    n_prev = kw; n_idx = r_idx + 6'd1; n_rdpend = 1'b0;
                    if (r_kcnt == 3'(nk - 4'd1)) begin
                        n_kcnt = '0; n_kround = r_kround + 4'd1;
                    end else begin
                        n_kcnt = r_kcnt + 3'd1;
                    end
                    if (r_idx == total - 6'd1) begin
                        n_keys_ready = 1'b1;
                        n_state = aes_pkg::ST_PREP;
                    end
                end
            end
            aes_pkg::ST_PREP: begin
                // start at the whitening key's round; CBC encrypt mixes the chain in first
                if (!dec && cbc) begin
                    n_st = r_st ^ r_chain;
                end
                n_rnd = dec ? nr : 4'd0;
                n_sub = '0; n_rdpend = 1'b0;
                n_state = aes_pkg::ST_ROUND;
            end
            aes_pkg::ST_ROUND: begin
                if (!r_rdpend) begin
                    rk.raddr = 6'({r_rnd, r_sub});
                    n_rdpend = 1'b1;
                end else begin
                    n_rdpend = 1'b0;
                    n_sub = r_sub + 2'd1;
                    if (r_sub != 2'd3) begin
                        n_kbuf = {r_kbuf[95:0], rdata};
                    end else if ((dec && r_rnd == nr) || (!dec && r_rnd == 4'd0)) begin
                        n_st = r_st ^ kfull;
                        n_rnd = dec ? r_rnd - 4'd1 : r_rnd + 4'd1;
                    end else begin
                        n_st = rnd_out;
                        if (rlast) begin
                            n_state = aes_pkg::ST_DONE;
                        end else begin
                            n_rnd = dec ? r_rnd - 4'd1 : r_rnd + 4'd1;
                        end
                    end
                end
            end
            aes_pkg::ST_DONE: begin
                // hold the finished word until the output register frees
                if (!r_ovalid || i_ready) begin
                    if (cbc) begin
                        if (dec) begin
                            n_res = r_st ^ r_chain;
                            n_chain = r_saved;
                        end else begin
                            n_res = r_st;
                            n_chain = r_st;
                        end
                    end else begin
                        n_res = r_st;
                    end
                    n_ovalid = 1'b1;
                    n_state = aes_pkg::ST_IDLE;
                end
            end
            default: n_state = aes_pkg::ST_IDLE;
        endcase
    end

    assign o_valid = r_ovalid;
    assign o_result_high = r_res[127:64];
    assign o_result_low = r_res[63:0];

`ifndef SYNTH
    a_busy_no_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != aes_pkg::ST_IDLE) |-> !o_ready)
        else $error("ready while a word is in flight");
    a_done_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == aes_pkg::ST_DONE) |=> o_valid)
        else $error("finished word not presented");
    a_expand_sets_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == aes_pkg::ST_PREP && !$past(i_cfg_we)) |-> r_keys_ready)
        else $error("rounds start without expanded keys");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> $stable(r_res))
        else $error("result changed under stall");
`endif
endmodule

// ===== hw/rtl/aes_rk_ram.sv =====
// Round-key store: one write port, one registered read port.
`timescale 1ns / 1ps
module aes_rk_ram (
    input  logic                    i_clk,
    input  aes_pkg::t_rk_req        i_req,
    output logic [31:0]             o_rdata
);
    logic [31:0] r_mem [aes_pkg::RkWords];

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        o_rdata <= r_mem[i_req.raddr];
    end
endmodule

// ===== hw/rtl/aes_round.sv =====
// One AES round on a 128-bit state, either direction, selected by flags.
`timescale 1ns / 1ps
module aes_round (
    input  logic [127:0] i_state,
    input  logic [127:0] i_key,
    input  logic         i_dec,
    input  logic         i_last,
    output logic [127:0] o_state
);
    logic [7:0]   s [16];
    logic [7:0]   t [16];
    logic [127:0] sh;
    logic [127:0] mx;

    always_comb begin
        for (int b = 0; b < 16; b++) begin
            s[b] = i_state[127-8*b -: 8];
        end
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                if (i_dec) begin
                    t[r + 4*((c + r) % 4)] = aes_pkg::sbox_rev(s[r + 4*c]);
                end else begin
                    t[r + 4*c] = aes_pkg::sbox(s[r + 4*((c + r) % 4)]);
                end
            end
        end
        for (int b = 0; b < 16; b++) begin
            sh[127-8*b -: 8] = t[b];
        end
        for (int c = 0; c < 4; c++) begin
            if (i_dec) begin
                mx[127-32*c -: 32] = aes_pkg::inv_mix_col(sh[127-32*c -: 32] ^ i_key[127-32*c -: 32]);
            end else begin
                mx[127-32*c -: 32] = aes_pkg::mix_col(sh[127-32*c -: 32]) ^ i_key[127-32*c -: 32];
            end
        end
        if (i_last) begin
            o_state = sh ^ i_key;
        end else begin
            o_state = mx;
        end
    end
endmodule

// ===== verif/aes_ecb_cbc_checker.sv =====
// Checker: predicts AES ECB/CBC results from observed words and compares them.
`timescale 1ns / 1ps
module aes_ecb_cbc_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [63:0] i_in_high,
    input  logic [63:0] i_in_low,
    input  logic        i_in_first,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [63:0] i_out_high,
    input  logic [63:0] i_out_low,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_wdata,
    output int          o_mismatches,
    output int          o_pending
);
    logic [7:0]   fwd_sub [256];
    logic [7:0]   inv_sub [256];
    logic [63:0]  key_w [4];
    logic [127:0] iv_reg;
    logic [1:0]   key_len;
    logic [1:0]   op_reg;
    logic [31:0]  sched [aes_pkg::RkWords];
    logic         sched_ok;
    logic [127:0] chain;
    logic [127:0] expected_blocks [$];
    int           mism;

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        acc = 8'h00;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) acc ^= a;
            a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
        end
        return acc;
    endfunction

    // build the substitution tables from the field inverse and the affine map
    initial begin
        logic [7:0] x, y, b;
        for (int i = 0; i < 256; i++) begin
            x = i[7:0];
            y = 8'h00;
            if (x != 8'h00)
                for (int j = 1; j < 256; j++)
                    if (gf_mul(x, j[7:0]) == 8'h01) y = j[7:0];
            b = y ^ {y[6:0], y[7]} ^ {y[5:0], y[7:6]} ^ {y[4:0], y[7:5]}
                ^ {y[3:0], y[7:4]} ^ 8'h63;
            fwd_sub[i] = b;
            inv_sub[b] = x;
        end
    end

    function automatic logic [7:0] byte_at(input logic [127:0] v, input int i);
        return v[127-8*i -: 8];
    endfunction

    function automatic int n_rounds();
        return 10 + 2 * ((key_len == 2'd3) ? 2 : int'(key_len));
    endfunction

    function automatic logic [31:0] sub_w(input logic [31:0] w);
        return {fwd_sub[w[31:24]], fwd_sub[w[23:16]], fwd_sub[w[15:8]], fwd_sub[w[7:0]]};
    endfunction

    task automatic expand_schedule();
        int nr, nk;
        logic [31:0] t;
        logic [7:0] rc;
        nr = n_rounds();
        nk = nr - 6;
        for (int i = 0; i < nk; i++)
            sched[i] = (i % 2) ? key_w[i/2][31:0] : key_w[i/2][63:32];
        for (int i = nk; i < 4 * (nr + 1); i++) begin
            t = sched[i-1];
            if (i % nk == 0) begin
                rc = 8'h01;
                for (int k = 1; k < i / nk; k++) rc = gf_mul(rc, 8'h02);
                t = sub_w({t[23:0], t[31:24]}) ^ {rc, 24'h0};
            end else if (nk > 6 && i % nk == 4) begin
                t = sub_w(t);
            end
            sched[i] = sched[i-nk] ^ t;
        end
        sched_ok = 1'b1;
    endtask

    function automatic logic [127:0] add_rk(input logic [127:0] s, input int r);
        for (int c = 0; c < 4; c++)
            for (int j = 0; j < 4; j++)
                s[127-8*(4*c+j) -: 8] ^= sched[4*r+c][31-8*j -: 8];
        return s;
    endfunction

    function automatic logic [127:0] sub_shift(input logic [127:0] s, input bit inv);
        logic [127:0] t;
        t = '0;
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                if (inv)
                    t[127-8*(r+4*((c+r)%4)) -: 8] = inv_sub[byte_at(s, r+4*c)];
                else
                    t[127-8*(r+4*c) -: 8] = fwd_sub[byte_at(s, r+4*((c+r)%4))];
        return t;
    endfunction

    function automatic logic [7:0] mix_coef(input bit inv, input int k);
        case (k)
            0:       return inv ? 8'd14 : 8'd2;
            1:       return inv ? 8'd11 : 8'd3;
            2:       return inv ? 8'd13 : 8'd1;
            default: return inv ? 8'd9  : 8'd1;
        endcase
    endfunction

    function automatic logic [127:0] mix_cols(input logic [127:0] s, input bit inv);
        logic [7:0] a [4];
        logic [7:0] v;
        for (int c = 0; c < 4; c++) begin
            for (int k = 0; k < 4; k++) a[k] = byte_at(s, 4*c+k);
            for (int r = 0; r < 4; r++) begin
                v = 8'h00;
                for (int k = 0; k < 4; k++) v ^= gf_mul(a[k], mix_coef(inv, (k+4-r)%4));
                s[127-8*(4*c+r) -: 8] = v;
            end
        end
        return s;
    endfunction

    function automatic logic [127:0] encrypt(input logic [127:0] s);
        int nr;
        nr = n_rounds();
        s = add_rk(s, 0);
        for (int r = 1; r < nr; r++) s = add_rk(mix_cols(sub_shift(s, 0), 0), r);
        return add_rk(sub_shift(s, 0), nr);
    endfunction

    function automatic logic [127:0] decrypt(input logic [127:0] s);
        int nr;
        nr = n_rounds();
        s = add_rk(s, nr);
        for (int r = nr - 1; r >= 1; r--) s = mix_cols(add_rk(sub_shift(s, 1), r), 1);
        return add_rk(sub_shift(s, 1), 0);
    endfunction

    task automatic predict_block(input logic [127:0] blk, input bit first);
        logic [127:0] s;
        if (!sched_ok) expand_schedule();
        if (op_reg[1] && first) chain = iv_reg;
        if (!op_reg[0]) begin
            s = encrypt(op_reg[1] ? (blk ^ chain) : blk);
            if (op_reg[1]) chain = s;
        end else begin
            s = decrypt(blk);
            if (op_reg[1]) begin
                s ^= chain;
                chain = blk;
            end
        end
        expected_blocks = {expected_blocks, s};
    endtask

    always @(posedge i_clk) begin
        logic [127:0] want;
        if (!i_rst_n) begin
            foreach (key_w[i]) key_w[i] = '0;
            iv_reg = '0;
            key_len = '0;
            op_reg = '0;
            sched_ok = 1'b0;
            chain = '0;
            expected_blocks.delete();
            mism = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    aes_pkg::CfgKey0:  begin key_w[0] = i_cfg_wdata; sched_ok = 1'b0; end
                    aes_pkg::CfgKey1:  begin key_w[1] = i_cfg_wdata; sched_ok = 1'b0; end
                    aes_pkg::CfgKey2:  begin key_w[2] = i_cfg_wdata; sched_ok = 1'b0; end
                    aes_pkg::CfgKey3:  begin key_w[3] = i_cfg_wdata; sched_ok = 1'b0; end
                    aes_pkg::CfgIvHi:  iv_reg[127:64] = i_cfg_wdata;
                    aes_pkg::CfgIvLo:  iv_reg[63:0] = i_cfg_wdata;
                    aes_pkg::CfgKeyLn: begin key_len = i_cfg_wdata[1:0]; sched_ok = 1'b0; end
                    aes_pkg::CfgMode:  op_reg = i_cfg_wdata[1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready)
                predict_block({i_in_high, i_in_low}, i_in_first);
            if (i_out_valid && i_out_ready) begin
                if (expected_blocks.size() == 0) begin
                    if (mism < 10)
                        $display("unexpected result word %h_%h", i_out_high, i_out_low);
                    mism++;
                end else begin
                    want = expected_blocks.pop_front();
                    if (want[127:64] !== i_out_high || want[63:0] !== i_out_low) begin
                        if (mism < 10)
                            $display("result mismatch: expected %h_%h actual %h_%h",
                                     want[127:64], want[63:0], i_out_high, i_out_low);
                        mism++;
                    end
                end
            end
        end
        o_mismatches <= mism;
        o_pending <= expected_blocks.size();
    end

endmodule

// ===== verif/aes_block_cipher_ecb_cbc_core_tb.sv =====
// Testbench top: drives AES ECB/CBC stimulus and reports the verdict.
`timescale 1ns / 1ps
module aes_block_cipher_ecb_cbc_core_tb;

    localparam logic [1:0] OpEncEcb = 2'd0;
    localparam logic [1:0] OpDecEcb = 2'd1;
    localparam logic [1:0] OpEncCbc = 2'd2;
    localparam logic [1:0] OpDecCbc = 2'd3;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [63:0] i_block_high = '0;
    logic [63:0] i_block_low = '0;
    logic        i_first_of_message = 1'b0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [63:0] o_result_high;
    logic [63:0] o_result_low;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_index = '0;
    logic [63:0] i_cfg_wdata = '0;

    int   mismatches, pending;
    int   n_sent = 0, n_got = 0;
    int   send_idle = 0, recv_idle = 0;
    int   hold_left = 0;
    logic hold_tog = 1'b0, hold_seen = 1'b0;
    logic [1:0] cur_mode = OpEncEcb;

    aes_block_cipher_ecb_cbc_core dut (.*);

    aes_ecb_cbc_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_valid), .i_in_ready(o_ready),
        .i_in_high(i_block_high), .i_in_low(i_block_low), .i_in_first(i_first_of_message),
        .i_out_valid(o_valid), .i_out_ready(i_ready),
        .i_out_high(o_result_high), .i_out_low(o_result_low),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_wdata(i_cfg_wdata),
        .o_mismatches(mismatches), .o_pending(pending)
    );

    initial forever #2 i_clk = ~i_clk;

    // receiver: random stalls, plus a long hold-off whenever the toggle flips
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (hold_tog != hold_seen) begin
            hold_seen <= hold_tog;
            hold_left <= 300;
            i_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) n_sent <= n_sent + 1;
            if (o_valid && i_ready) n_got <= n_got + 1;
        end
    end

    task automatic send_word(input logic [63:0] hi, input logic [63:0] lo, input bit first);
        if ($urandom_range(99) < send_idle) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle);
        end
        i_valid <= 1'b1;
        i_block_high <= hi;
        i_block_low <= lo;
        i_first_of_message <= first;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // drop valid and hold until every result has been taken
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (n_sent != n_got) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [63:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_mode(input logic [1:0] m);
        cur_mode = m;
        cfg_write(aes_pkg::CfgMode, {62'h0, m});
    endtask

    function automatic logic [63:0] rand_word();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    initial begin
        int seg_len;
        bit first;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // chain without a first word: CBC starts from the zero chain
        set_mode(OpEncCbc);
        send_word('0, '0, 1'b0);
        send_word('1, '1, 1'b0);
        drain();
        cfg_write(aes_pkg::CfgKey0, 64'h0001020304050607);
        cfg_write(aes_pkg::CfgKey1, 64'h08090a0b0c0d0e0f);
        cfg_write(aes_pkg::CfgKey2, 64'h1011121314151617);
        cfg_write(aes_pkg::CfgKey3, 64'h18191a1b1c1d1e1f);
        cfg_write(aes_pkg::CfgIvHi, '1);
        cfg_write(aes_pkg::CfgIvLo, 64'h0123456789abcdef);
        for (int kl = 0; kl < 4; kl++) begin
            drain();
            cfg_write(aes_pkg::CfgKeyLn, 64'(kl));
            set_mode(OpEncEcb);
            send_word(64'h0011223344556677, 64'h8899aabbccddeeff, 1'b1);
            drain();
            set_mode(OpDecEcb);
            send_word(64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a, 1'b0);
            send_word('1, '0, 1'b1);
        end
        drain();
        set_mode(OpEncCbc);
        send_word(64'h0011223344556677, 64'h8899aabbccddeeff, 1'b1);
        send_word('0, '1, 1'b0);
        drain();
        // mode change mid-message: chain carries on
        set_mode(OpDecCbc);
        send_word('1, '1, 1'b0);
        send_word(64'h8000000000000000, 64'h1, 1'b1);
        send_word('0, '0, 1'b0);
        drain();
        // long hold-off while words keep coming, so the input stalls
        hold_tog <= ~hold_tog;
        repeat (4) send_word(rand_word(), rand_word(), 1'b0);
        drain();

        while (n_sent < 1850) begin
            drain();
            if (n_sent < 640) begin
                send_idle = 14; recv_idle = 58;
            end else if (n_sent < 1250) begin
                send_idle = 58; recv_idle = 14;
            end else begin
                send_idle = 0; recv_idle = 0;
            end
            if ($urandom_range(2) == 0) begin
                cfg_write(aes_pkg::CfgKey0, rand_word());
                cfg_write(aes_pkg::CfgKey1, rand_word());
                cfg_write(aes_pkg::CfgKey2, rand_word());
                cfg_write(aes_pkg::CfgKey3, rand_word());
                cfg_write(aes_pkg::CfgKeyLn, {62'h0, 2'($urandom_range(3))});
            end
            if ($urandom_range(1) == 0) begin
                cfg_write(aes_pkg::CfgIvHi, rand_word());
                cfg_write(aes_pkg::CfgIvLo, rand_word());
            end
            set_mode(2'($urandom_range(3)));
            // long hold-off so the block fills up and stalls its input
            if ($urandom_range(19) == 0) hold_tog <= ~hold_tog;
            seg_len = ($urandom_range(9) == 0) ? $urandom_range(40, 80) : $urandom_range(3, 40);
            for (int k = 0; k < seg_len; k++) begin
                if (cur_mode[1])
                    first = (k == 0) ? ($urandom_range(9) != 0) : ($urandom_range(19) == 0);
                else
                    first = 1'($urandom_range(1));
                send_word(rand_word(), rand_word(), first);
            end
        end
        drain();
        repeat (300) @(posedge i_clk);
        if (mismatches == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

// ===== aes_block_cipher_ecb_cbc_core.f =====
hw/rtl/aes_pkg.sv
hw/rtl/aes_rk_ram.sv
hw/rtl/aes_round.sv
hw/rtl/aes_block_cipher_ecb_cbc_core.sv
verif/aes_ecb_cbc_checker.sv
verif/aes_block_cipher_ecb_cbc_core_tb.sv
